/* src/pidaw_pkg.sv */
// Shared types, constants and arithmetic helpers of the PID controller block.
package pidaw_pkg;

    localparam int DataW    = 32;
    localparam int FracW    = 16;
    localparam int CoefW    = 17;
    localparam int DtW      = DataW - 1;
    localparam int NumW     = 33;                // magnitude of a divider numerator
    localparam int DvdW     = NumW + FracW;      // dividend after the fraction shift
    localparam int DivCntW  = 6;
    localparam logic [DivCntW-1:0] DIV_STEPS = DivCntW'(DvdW);
    localparam logic [CoefW-1:0] COEF_ONE    = 17'h10000;

    localparam logic [2:0] REG_GAIN_P  = 3'd0;
    localparam logic [2:0] REG_GAIN_I  = 3'd1;
    localparam logic [2:0] REG_GAIN_D  = 3'd2;
    localparam logic [2:0] REG_FILTER  = 3'd3;
    localparam logic [2:0] REG_OUT_MIN = 3'd4;
    localparam logic [2:0] REG_OUT_MAX = 3'd5;
    localparam logic [2:0] REG_MODE    = 3'd6;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_MAX  = 2'd1;
    localparam logic [1:0] CLAMP_MIN  = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_M_INT,
        OP_W_INT,
        OP_DIV_D,
        OP_DIV_STEP,
        OP_W_DER,
        OP_M_P,
        OP_W_P,
        OP_M_I,
        OP_W_I,
        OP_M_D,
        OP_W_D,
        OP_M_F1,
        OP_W_F1,
        OP_M_F2,
        OP_W_F2,
        OP_SUM,
        OP_CLAMP,
        OP_DIV_B,
        OP_W_BACK,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic zero_dt;
        logic div_busy;
        logic filt_en;
        logic back_calc;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic signed [DataW-1:0] val;
        logic                    ovf;
    } satres_t;

    function automatic satres_t sat36(input logic signed [35:0] v);
        satres_t r;
        r.ovf = 1'b0;
        if (v > 36'sh07FFFFFFF) begin
            r.val = 32'sh7FFFFFFF;
            r.ovf = 1'b1;
        end
        else if (v < 36'shF80000000) begin
            r.val = 32'sh80000000;
            r.ovf = 1'b1;
        end
        else begin
            r.val = v[31:0];
        end
        return r;
    endfunction

    // Apply a sign to a 49-bit magnitude, saturating to the signed range.
    function automatic satres_t sign_sat(input logic neg, input logic [48:0] m);
        satres_t     r;
        logic [48:0] lim;
        logic [32:0] mm;
        lim   = neg ? 49'h80000000 : 49'h7FFFFFFF;
        r.ovf = (m > lim);
        mm    = r.ovf ? lim[32:0] : m[32:0];
        r.val = neg ? 32'(33'd0 - mm) : mm[31:0];
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

endpackage

/* src/pidaw_ctrl.sv */
// Step sequencer of the PID controller: walks one item through the datapath.
module pidaw_ctrl import pidaw_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output op_t     op
);

    typedef enum logic [4:0] {
        S_IDLE, S_ERR, S_M_INT, S_W_INT, S_DIV_D, S_RUN_D, S_W_DER,
        S_M_P, S_W_P, S_M_I, S_W_I, S_M_D, S_W_D,
        S_M_F1, S_W_F1, S_M_F2, S_W_F2, S_SUM, S_CLAMP,
        S_DIV_B, S_RUN_B, S_W_BACK, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_ERR;
            S_ERR:    state_next = S_M_INT;
            S_M_INT:  state_next = S_W_INT;
            S_W_INT:  state_next = status.zero_dt ? S_W_DER : S_DIV_D;
            S_DIV_D:  state_next = S_RUN_D;
            S_RUN_D:  if (!status.div_busy) state_next = S_W_DER;
            S_W_DER:  state_next = S_M_P;
            S_M_P:    state_next = S_W_P;
            S_W_P:    state_next = S_M_I;
            S_M_I:    state_next = S_W_I;
            S_W_I:    state_next = S_M_D;
            S_M_D:    state_next = S_W_D;
            S_W_D:    state_next = status.filt_en ? S_M_F1 : S_SUM;
            S_M_F1:   state_next = S_W_F1;
            S_W_F1:   state_next = S_M_F2;
            S_M_F2:   state_next = S_W_F2;
            S_W_F2:   state_next = S_SUM;
            S_SUM:    state_next = S_CLAMP;
            S_CLAMP:  state_next = status.back_calc ? S_DIV_B : S_OUT;
            S_DIV_B:  state_next = S_RUN_B;
            S_RUN_B:  if (!status.div_busy) state_next = S_W_BACK;
            S_W_BACK: state_next = S_OUT;
            S_OUT:    if (status.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:   op = in_valid ? OP_LOAD : OP_NONE;
            S_ERR:    op = OP_ERR;
            S_M_INT:  op = OP_M_INT;
            S_W_INT:  op = OP_W_INT;
            S_DIV_D:  op = OP_DIV_D;
            S_RUN_D:  op = OP_DIV_STEP;
            S_W_DER:  op = OP_W_DER;
            S_M_P:    op = OP_M_P;
            S_W_P:    op = OP_W_P;
            S_M_I:    op = OP_M_I;
            S_W_I:    op = OP_W_I;
            S_M_D:    op = OP_M_D;
            S_W_D:    op = OP_W_D;
            S_M_F1:   op = OP_M_F1;
            S_W_F1:   op = OP_W_F1;
            S_M_F2:   op = OP_M_F2;
            S_W_F2:   op = OP_W_F2;
            S_SUM:    op = OP_SUM;
            S_CLAMP:  op = OP_CLAMP;
            S_DIV_B:  op = OP_DIV_B;
            S_RUN_B:  op = OP_DIV_STEP;
            S_W_BACK: op = OP_W_BACK;
            S_OUT:    op = OP_OUT;
            default:  op = OP_NONE;
        endcase
    end

endmodule

/* src/pidaw_dp.sv */
// Datapath of the PID controller: registers, shared multiplier and serial divider.
module pidaw_dp import pidaw_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  op_t                     op,
    output status_t                 status,
    input  logic                    cfg_wr_en,
    input  logic [2:0]              cfg_index,
    input  logic [DataW-1:0]        cfg_data,
    input  logic signed [DataW-1:0] measured,
    input  logic signed [DataW-1:0] target,
    input  logic [DtW-1:0]          elapsed,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [DataW-1:0] control_out,
    output logic signed [DataW-1:0] p_term,
    output logic signed [DataW-1:0] i_term,
    output logic signed [DataW-1:0] d_term,
    output logic [1:0]              clamp_state,
    output logic                    overflow,
    output logic                    zero_elapsed
);

    logic signed [DataW-1:0] gain_p_reg, gain_i_reg, gain_d_reg, out_min_reg, out_max_reg;
    logic [CoefW-1:0]        coef_reg;
    logic [1:0]              mode_reg;

    logic signed [DataW-1:0] meas_reg, tgt_reg, err_reg, integ_reg, prev_err_reg;
    logic signed [DataW-1:0] prev_fd_reg, deriv_reg, p_reg, i_reg, d_reg, f1_reg, x_reg;
    logic [DtW-1:0]          dt_reg;
    logic [1:0]              clamp_reg;
    logic                    ovf_reg, zero_reg;

    logic [63:0]             prod_reg;
    logic                    pneg_reg;

    logic [DataW-1:0]        rem_reg, den_reg;
    logic [DvdW-1:0]         dvd_reg, quo_reg;
    logic                    dneg_reg;
    logic [DivCntW-1:0]      dcnt_reg;

    logic                    out_valid_reg;
    logic signed [DataW-1:0] out_x_reg, out_p_reg, out_i_reg, out_d_reg;
    logic [1:0]              out_clamp_reg;
    logic                    out_ovf_reg, out_zero_reg;

    // Multiplier operand selection
    logic signed [DataW-1:0] ma_s, mb_s;
    logic [DataW-1:0]        ma, mb;
    logic [63:0]             prod_c;
    logic [CoefW-1:0]        coef_a, coef_b;
    satres_t                 mres, dres, s_err, s_int, s_f, s_sum;
    logic signed [32:0]      diff_err;
    logic signed [33:0]      dnum_d, dnum_b;
    logic signed [33:0]      dnum;
    logic [NumW-1:0]         dnum_mag;
    logic [32:0]             rem_sh;
    logic                    hit_max, hit_min;
    logic                    out_free;

    assign coef_a = (coef_reg > COEF_ONE) ? COEF_ONE : coef_reg;
    assign coef_b = COEF_ONE - coef_a;

    always_comb
    begin
        ma_s = err_reg;
        mb_s = {1'b0, dt_reg};
        unique case (op)
            OP_M_P:  begin ma_s = gain_p_reg;               mb_s = err_reg;     end
            OP_M_I:  begin ma_s = gain_i_reg;               mb_s = integ_reg;   end
            OP_M_D:  begin ma_s = gain_d_reg;               mb_s = deriv_reg;   end
            OP_M_F1: begin ma_s = 32'(coef_b);              mb_s = d_reg;       end
            OP_M_F2: begin ma_s = 32'(coef_a);              mb_s = prev_fd_reg; end
            default: begin ma_s = err_reg;                  mb_s = {1'b0, dt_reg}; end
        endcase
    end

    assign ma     = mag32(ma_s);
    assign mb     = mag32(mb_s);
    assign prod_c = ma * mb;
    assign mres   = sign_sat(pneg_reg, {1'b0, prod_reg[63:FracW]});
    assign dres   = sign_sat(dneg_reg, quo_reg);

    assign diff_err = {tgt_reg[31], tgt_reg} - {meas_reg[31], meas_reg};
    assign s_err    = sat36(36'(diff_err));
    assign s_int    = sat36(36'(mres.val) + 36'(integ_reg));
    assign s_f      = sat36(36'(f1_reg) + 36'(mres.val));
    assign s_sum    = sat36(36'(p_reg) + 36'(i_reg) + 36'(d_reg));

    assign dnum_d = 34'(err_reg) - 34'(prev_err_reg);
    assign dnum_b = ((clamp_reg == CLAMP_MAX) ? 34'(out_max_reg) : 34'(out_min_reg))
                    - 34'(p_reg) - 34'(d_reg);
    assign dnum     = (op == OP_DIV_B) ? dnum_b : dnum_d;
    assign dnum_mag = dnum[33] ? NumW'(-dnum) : NumW'(dnum);
    assign rem_sh   = {rem_reg, dvd_reg[DvdW-1]};

    assign hit_max  = mode_reg[1] && (x_reg > out_max_reg);
    assign hit_min  = mode_reg[1] && (x_reg < out_min_reg);
    assign out_free = !out_valid_reg || out_ready;

    assign status.zero_dt   = (dt_reg == '0);
    assign status.div_busy  = (dcnt_reg != '0);
    assign status.filt_en   = mode_reg[0];
    assign status.back_calc = (hit_max || hit_min) && (gain_i_reg != '0);
    assign status.out_free  = out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            coef_reg    <= '0;
            out_min_reg <= 32'sh80000000;
            out_max_reg <= 32'sh7FFFFFFF;
            mode_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GAIN_P:  gain_p_reg  <= cfg_data;
                REG_GAIN_I:  gain_i_reg  <= cfg_data;
                REG_GAIN_D:  gain_d_reg  <= cfg_data;
                REG_FILTER:  coef_reg    <= cfg_data[CoefW-1:0];
                REG_OUT_MIN: out_min_reg <= cfg_data;
                REG_OUT_MAX: out_max_reg <= cfg_data;
                REG_MODE:    mode_reg    <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    // Loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
            prev_fd_reg  <= '0;
            dcnt_reg     <= '0;
            clamp_reg    <= CLAMP_NONE;
        end
        else
        begin
            unique case (op)
                OP_W_INT:  integ_reg <= s_int.val;
                OP_W_DER:  prev_err_reg <= err_reg;
                OP_W_F2:   prev_fd_reg <= s_f.val;
                OP_SUM:    clamp_reg <= CLAMP_NONE;
                OP_CLAMP:
                begin
                    priority if (hit_max)
                        clamp_reg <= CLAMP_MAX;
                    else if (hit_min)
                        clamp_reg <= CLAMP_MIN;
                    else
                        clamp_reg <= CLAMP_NONE;
                    if ((hit_max || hit_min) && gain_i_reg == '0)
                        integ_reg <= '0;
                end
                OP_W_BACK: integ_reg <= dres.val;
                OP_DIV_D, OP_DIV_B: dcnt_reg <= DIV_STEPS;
                OP_DIV_STEP: if (dcnt_reg != '0) dcnt_reg <= dcnt_reg - 1'b1;
                default:   ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                meas_reg <= measured;
                tgt_reg  <= target;
                dt_reg   <= elapsed;
            end
            OP_ERR:
            begin
                err_reg  <= s_err.val;
                ovf_reg  <= s_err.ovf;
                zero_reg <= (dt_reg == '0);
            end
            OP_M_INT, OP_M_P, OP_M_I, OP_M_D, OP_M_F1, OP_M_F2:
            begin
                prod_reg <= prod_c;
                pneg_reg <= ma_s[31] ^ mb_s[31];
            end
            OP_W_INT: ovf_reg <= ovf_reg | mres.ovf | s_int.ovf;
            OP_DIV_D, OP_DIV_B:
            begin
                dvd_reg  <= {dnum_mag, FracW'(0)};
                quo_reg  <= '0;
                rem_reg  <= '0;
                den_reg  <= (op == OP_DIV_B) ? mag32(gain_i_reg) : 32'(dt_reg);
                dneg_reg <= (op == OP_DIV_B) ? (dnum[33] ^ gain_i_reg[31]) : dnum[33];
            end
            OP_DIV_STEP:
            begin
                if (dcnt_reg != '0)
                begin
                    dvd_reg <= dvd_reg << 1;
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= 32'(rem_sh - {1'b0, den_reg});
                        quo_reg <= {quo_reg[DvdW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[31:0];
                        quo_reg <= {quo_reg[DvdW-2:0], 1'b0};
                    end
                end
            end
            OP_W_DER:
            begin
                if (zero_reg)
                    deriv_reg <= '0;
                else
                begin
                    deriv_reg <= dres.val;
                    ovf_reg   <= ovf_reg | dres.ovf;
                end
            end
            OP_W_P:
            begin
                p_reg   <= mres.val;
                ovf_reg <= ovf_reg | mres.ovf;
            end
            OP_W_I:
            begin
                i_reg   <= mres.val;
                ovf_reg <= ovf_reg | mres.ovf;
            end
            OP_W_D:
            begin
                d_reg   <= mres.val;
                ovf_reg <= ovf_reg | mres.ovf;
            end
            OP_W_F1:
            begin
                f1_reg  <= mres.val;
                ovf_reg <= ovf_reg | mres.ovf;
            end
            OP_W_F2:
            begin
                d_reg   <= s_f.val;
                ovf_reg <= ovf_reg | mres.ovf | s_f.ovf;
            end
            OP_SUM:
            begin
                x_reg   <= s_sum.val;
                ovf_reg <= ovf_reg | s_sum.ovf;
            end
            OP_CLAMP:
            begin
                priority if (hit_max)
                    x_reg <= out_max_reg;
                else if (hit_min)
                    x_reg <= out_min_reg;
            end
            OP_W_BACK: ovf_reg <= ovf_reg | dres.ovf;
            default:   ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (op == OP_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_OUT && out_free)
        begin
            out_x_reg     <= x_reg;
            out_p_reg     <= p_reg;
            out_i_reg     <= i_reg;
            out_d_reg     <= d_reg;
            out_clamp_reg <= clamp_reg;
            out_ovf_reg   <= ovf_reg;
            out_zero_reg  <= zero_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign control_out  = out_x_reg;
    assign p_term       = out_p_reg;
    assign i_term       = out_i_reg;
    assign d_term       = out_d_reg;
    assign clamp_state  = out_clamp_reg;
    assign overflow     = out_ovf_reg;
    assign zero_elapsed = out_zero_reg;

endmodule

/* src/pid_controller_antiwindup_top.sv */
// Top level of the PID controller with derivative filter and anti-windup.
// The derivative filter adds the filter products, and a clamp that back-calculates
// the integral adds a second division; a zero elapsed time skips the derivative
// division. One item at a time: a new item is taken only once the last result is
// in the output register; the 49-step serial divider takes most of the time.
// Reset: asynchronous, active low; clears gains, mode, loop state; limits to full range.
module pid_controller_antiwindup_top import pidaw_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [2:0]              cfg_index,
    input  logic [DataW-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [DataW-1:0] measured,
    input  logic signed [DataW-1:0] target,
    input  logic [DtW-1:0]          elapsed,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [DataW-1:0] control_out,
    output logic signed [DataW-1:0] p_term,
    output logic signed [DataW-1:0] i_term,
    output logic signed [DataW-1:0] d_term,
    output logic [1:0]              clamp_state,
    output logic                    overflow,
    output logic                    zero_elapsed
);

    op_t     op;
    status_t status;

    // Sequencer: takes an item while idle, then steps the datapath
    pidaw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    // Datapath: one shared 32x32 multiplier, one restoring divider,
    // and an output register so a finished item may wait for the sink
    pidaw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .measured     (measured),
        .target       (target),
        .elapsed      (elapsed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .control_out  (control_out),
        .p_term       (p_term),
        .i_term       (i_term),
        .d_term       (d_term),
        .clamp_state  (clamp_state),
        .overflow     (overflow),
        .zero_elapsed (zero_elapsed)
    );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the fixed-point PID controller with filter and anti-windup.
module tb_top;
    import pidaw_pkg::*;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 125;

    // One loop step as the block reports it.
    typedef struct {
        logic [31:0] ctl;
        logic [31:0] p;
        logic [31:0] i;
        logic [31:0] d;
        logic [1:0]  clamp;
        logic        ovf;
        logic        zdt;
    } pid_step_t;

    // Directed stimulus row; known marks rows whose outcome is typed in below.
    typedef struct {
        logic [31:0] meas;
        logic [31:0] tgt;
        logic [30:0] dt;
        int          preset;
        bit          known;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic signed [31:0] measured;
    logic signed [31:0] target;
    logic [30:0] elapsed;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] control_out;
    logic signed [31:0] p_term;
    logic signed [31:0] i_term;
    logic signed [31:0] d_term;
    logic [1:0]  clamp_state;
    logic        overflow;
    logic        zero_elapsed;

    // Mirror of the configuration and loop state.
    longint          kp, ki, kd, lim_lo, lim_hi;
    longint unsigned coef;
    logic [1:0]      ctl_mode;
    longint          integ, last_err, last_fderiv;

    pid_step_t pending_steps[$];
    bit        failed;
    int        results_seen;

    // Directed rows: reset settings first (typed outcome), then the three presets.
    stim_row_t dir_rows [18] = '{
        '{32'h0000_0000, 32'h0000_0000, 31'h0001_0000, 0, 1'b1},
        '{32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 1'b1},
        '{32'h7FFF_FFFF, 32'h8000_0000, 31'h0000_0000, 0, 1'b1},
        '{32'h0001_0000, 32'h0000_0000, 31'h0000_0001, 0, 1'b1},
        '{32'hFFFF_FFFF, 32'h0000_0001, 31'h7FFF_FFFF, 0, 1'b1},
        '{32'h0000_0000, 32'h0005_0000, 31'h0001_0000, 1, 1'b0},
        '{32'h0000_0000, 32'h0005_0000, 31'h0001_0000, 1, 1'b0},
        '{32'h0000_0000, 32'hFFE0_0000, 31'h0000_8000, 1, 1'b0},
        '{32'h0000_0000, 32'h0020_0000, 31'h0000_0000, 1, 1'b0},
        '{32'h0001_0000, 32'h0001_8000, 31'h0000_0001, 1, 1'b0},
        '{32'h0000_0000, 32'h0001_0000, 31'h0001_0000, 2, 1'b0},
        '{32'h0000_0000, 32'hFFFF_0000, 31'h0001_0000, 2, 1'b0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 2, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 31'h0000_0000, 2, 1'b0},
        '{32'h0000_0000, 32'h0000_0000, 31'h0001_0000, 3, 1'b0},
        '{32'h0000_0000, 32'h0001_0000, 31'h0001_0000, 3, 1'b0},
        '{32'h0000_0000, 32'hFFFF_0000, 31'h0000_0100, 3, 1'b0},
        '{32'h8000_0000, 32'h8000_0000, 31'h0000_0000, 3, 1'b0}
    };

    pid_controller_antiwindup_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .measured     (measured),
        .target       (target),
        .elapsed      (elapsed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .control_out  (control_out),
        .p_term       (p_term),
        .i_term       (i_term),
        .d_term       (d_term),
        .clamp_state  (clamp_state),
        .overflow     (overflow),
        .zero_elapsed (zero_elapsed)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------
    // Fixed-point arithmetic of the loop: exact on magnitudes, truncate
    // toward zero, saturate to 32 signed bits and flag the saturation.
    // ---------------------------------------------------------------
    function automatic longint clip_q(input longint v, inout bit o);
        if (v > QMAX)
        begin
            o = 1'b1;
            return QMAX;
        end
        if (v < QMIN)
        begin
            o = 1'b1;
            return QMIN;
        end
        return v;
    endfunction

    function automatic longint unsigned abs_q(input longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint signed_sat(input bit neg, input longint unsigned m,
                                          input bit big, inout bit o);
        longint unsigned lim;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (big || m > lim)
        begin
            o = 1'b1;
            m = lim;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint q_mul(input longint a, input longint b, inout bit o);
        longint unsigned prod;
        prod = abs_q(a) * abs_q(b);
        return signed_sat((a < 0) != (b < 0), prod >> 16, 1'b0, o);
    endfunction

    function automatic longint q_div(input longint num, input longint den, inout bit o);
        longint unsigned n, dd, q;
        bit big;
        n   = abs_q(num);
        dd  = abs_q(den);
        q   = n / dd;
        big = q > (64'd1 << 15);
        if (!big)
            q = (n << 16) / dd;
        return signed_sat((num < 0) != (den < 0), q, big, o);
    endfunction

    // Advance the loop state by one item and return what the block should report.
    function automatic pid_step_t pid_advance(input logic [31:0] meas_v,
                                              input logic [31:0] tgt_v,
                                              input logic [30:0] dt_v);
        pid_step_t r;
        bit o;
        longint err, deriv, pp, ii, dd, x, a, dt;
        o  = 1'b0;
        dt = longint'(dt_v);
        err   = clip_q(longint'(signed'(tgt_v)) - longint'(signed'(meas_v)), o);
        integ = clip_q(q_mul(err, dt, o) + integ, o);
        deriv = (dt == 0) ? 0 : q_div(err - last_err, dt, o);
        last_err = err;
        pp = q_mul(kp, err, o);
        ii = q_mul(ki, integ, o);
        dd = q_mul(kd, deriv, o);
        if (ctl_mode[0])
        begin
            a  = (coef > 65536) ? 65536 : longint'(coef);
            dd = clip_q(q_mul(65536 - a, dd, o) + q_mul(a, last_fderiv, o), o);
            last_fderiv = dd;
        end
        x = clip_q(pp + ii + dd, o);
        r.clamp = CLAMP_NONE;
        if (ctl_mode[1])
        begin
            if (x > lim_hi)
            begin
                integ   = (ki != 0) ? q_div(lim_hi - pp - dd, ki, o) : 0;
                x       = lim_hi;
                r.clamp = CLAMP_MAX;
            end
            else if (x < lim_lo)
            begin
                integ   = (ki != 0) ? q_div(lim_lo - pp - dd, ki, o) : 0;
                x       = lim_lo;
                r.clamp = CLAMP_MIN;
            end
        end
        r.ctl = x[31:0];
        r.p   = pp[31:0];
        r.i   = ii[31:0];
        r.d   = dd[31:0];
        r.ovf = o;
        r.zdt = (dt == 0);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Configuration: write while idle and mirror the write.
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_GAIN_P:  kp      = longint'(signed'(val));
            REG_GAIN_I:  ki      = longint'(signed'(val));
            REG_GAIN_D:  kd      = longint'(signed'(val));
            REG_FILTER:  coef    = longint'(val[16:0]);
            REG_OUT_MIN: lim_lo  = longint'(signed'(val));
            REG_OUT_MAX: lim_hi  = longint'(signed'(val));
            REG_MODE:    ctl_mode = val[1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] gp, input logic [31:0] gi,
                             input logic [31:0] gd, input logic [31:0] fc,
                             input logic [31:0] lo, input logic [31:0] hi,
                             input logic [31:0] md);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_FILTER, fc);
        write_reg(REG_OUT_MIN, lo);
        write_reg(REG_OUT_MAX, hi);
        write_reg(REG_MODE, md);
        cfg_wr_en <= 1'b0;
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_preset(input int k);
        drain_block();
        case (k)
            0: write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
            1: write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0000_8000,
                         32'hFFF6_0000, 32'h000A_0000, 32'd3);
            // gain_i zero clears the integral on a clamp; coefficient above one
            2: write_all(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0001_FFFF,
                         32'hFFFF_0000, 32'h0001_0000, 32'd3);
            // inverted limits: the max test wins
            default: write_all(32'h0002_0000, 32'h8000_0000, 32'h0000_1000, 32'h0,
                               32'h0005_0000, 32'hFFFB_0000, 32'd2);
        endcase
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2:    return $urandom();
            default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h40000)
                                                  : -$urandom_range(0, 32'h40000);
        endcase
    endfunction

    task automatic random_config();
        logic [31:0] lo, hi, swap;
        lo = -$urandom_range(0, 32'h0040_0000);
        hi = $urandom_range(0, 32'h0040_0000);
        case ($urandom_range(0, 9))
            0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
            1: begin swap = lo; lo = hi; hi = swap; end
            2: begin lo = $urandom(); hi = $urandom(); end
            default: ;
        endcase
        drain_block();
        write_all(pick_gain(), pick_gain(), pick_gain(),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 32'h1FFFF)
                                            : $urandom_range(0, 32'h10000),
                  lo, hi, $urandom_range(0, 3));
    endtask

    // ---------------------------------------------------------------
    // Item stimulus
    // ---------------------------------------------------------------
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 3))
                   0:       return 32'h8000_0000;
                   1:       return 32'h7FFF_FFFF;
                   2:       return 32'hFFFF_FFFF;
                   default: return 32'h0;
               endcase
            1, 2, 3: return $urandom();
            default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h80000)
                                                  : -$urandom_range(0, 32'h80000);
        endcase
    endfunction

    function automatic logic [30:0] pick_elapsed();
        case ($urandom_range(0, 19))
            0, 1:    return 31'd0;
            2, 3:    return 31'($urandom_range(1, 256));
            4, 5:    return 31'($urandom());
            6:       return 31'h7FFF_FFFF;
            default: return 31'($urandom_range(32'h100, 32'h40000));
        endcase
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Offer one item, hold it until taken, then record what it should produce.
    task automatic send_item(input logic [31:0] m, input logic [31:0] t,
                             input logic [30:0] dt, input int gap, input bit known);
        pid_step_t e;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        measured <= m;
        target   <= t;
        elapsed  <= dt;
        do
            @(posedge clk);
        while (!in_ready);
        e = pid_advance(m, t, dt);
        if (known)
        begin
            // all gains zero and mode zero: every term is zero, nothing clamps
            e.ctl   = 32'h0;
            e.p     = 32'h0;
            e.i     = 32'h0;
            e.d     = 32'h0;
            e.clamp = CLAMP_NONE;
            e.zdt   = (dt == 31'd0);
        end
        pending_steps.push_back(e);
    endtask

    // ---------------------------------------------------------------
    // Sender: reset, directed rows, random phases, then drain and report.
    // ---------------------------------------------------------------
    initial
    begin
        int   preset_now;
        bit   quiet;
        failed       = 1'b0;
        results_seen = 0;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_GAIN_P;
        cfg_data  = 32'h0;
        in_valid  = 1'b0;
        measured  = 32'sh0;
        target    = 32'sh0;
        elapsed   = 31'h0;
        kp = 0; ki = 0; kd = 0; coef = 0; ctl_mode = 2'd0;
        lim_lo = QMIN; lim_hi = QMAX;
        integ = 0; last_err = 0; last_fderiv = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the reset settings apply to the first rows
        preset_now = 0;
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].preset != preset_now)
            begin
                preset_now = dir_rows[k].preset;
                load_preset(preset_now);
            end
            send_item(dir_rows[k].meas, dir_rows[k].tgt, dir_rows[k].dt,
                      pick_gap(1'b0), dir_rows[k].known);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_config();
            // every third phase runs back to back with no sender gaps
            quiet = (ph % 3 == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(pick_value(), pick_value(), pick_elapsed(), pick_gap(quiet), 1'b0);
        end

        in_valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        // allow for a stray late result
        repeat (150) @(posedge clk);
        if (!failed && pending_steps.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            $error("%s: expected %h, got %h", nm, e, a);
            failed = 1'b1;
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls, one long hold-off, compare in order.
    // ---------------------------------------------------------------
    initial
    begin
        pid_step_t e;
        int  stall_left;
        bit  held;
        out_ready  = 1'b0;
        stall_left = 0;
        held       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_steps.size() == 0)
                begin
                    $error("result with no item outstanding");
                    failed = 1'b1;
                end
                else
                begin
                    e = pending_steps.pop_front();
                    check_field("control_out", e.ctl, control_out);
                    check_field("p_term", e.p, p_term);
                    check_field("i_term", e.i, i_term);
                    check_field("d_term", e.d, d_term);
                    check_field("clamp_state", 32'(e.clamp), 32'(clamp_state));
                    check_field("overflow", 32'(e.ovf), 32'(overflow));
                    check_field("zero_elapsed", 32'(e.zdt), 32'(zero_elapsed));
                end
            end
            // hold off once for long enough that the block backs up into its input
            if (!held && results_seen == 300)
            begin
                held       = 1'b1;
                stall_left = 600;
            end
            else if (stall_left == 0)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2: stall_left = $urandom_range(1, 3);
                    3:       stall_left = $urandom_range(10, 80);
                    default: stall_left = 0;
                endcase
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        #15_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
